// File: sv/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg: shared types, constants and the UTF-8 decoder
// Field widths, character codes and the decode function used by the
// wrapped text measurement block.
// ----------------------------------------------------------------------------
`default_nettype none

package wtm_pkg;

    localparam int GLYPH_DEPTH_DEF = 256;
    localparam int KERN_DEPTH_DEF  = 512;
    localparam int TEXT_DEPTH_DEF  = 1024;

    localparam int CP_W   = 21;
    localparam int ADV_W  = 16;
    localparam int IDX_W  = 9;
    localparam int CFG_W  = 15;
    localparam int CFGI_W = 2;

    localparam logic [1:0] OP_GLYPH = 2'd0;
    localparam logic [1:0] OP_KERN  = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    localparam logic [CFGI_W-1:0] REG_WRAP_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_LINE_HEIGHT = 2'd1;
    localparam logic [CFGI_W-1:0] REG_GLYPH_COUNT = 2'd2;
    localparam logic [CFGI_W-1:0] REG_KERN_COUNT  = 2'd3;

    localparam logic [CP_W-1:0] CP_QUESTION    = 21'h00003f;
    localparam logic [CP_W-1:0] CP_SPACE       = 21'h000020;
    localparam logic [CP_W-1:0] CP_HYPHEN      = 21'h00002d;
    localparam logic [CP_W-1:0] CP_NEWLINE     = 21'h00000a;
    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      len;
    } decode_t;

    // Decodes one UTF-8 sequence; an invalid lead or continuation consumes
    // a single byte and yields the replacement character.
    function automatic decode_t utf8_decode(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
        decode_t d;
        logic c1, c2, c3;
        c1 = (b1[7:6] == 2'b10);
        c2 = (b2[7:6] == 2'b10);
        c3 = (b3[7:6] == 2'b10);
        if (b0 == 8'h00) begin
            d.cp  = '0;
            d.len = 3'd0;
        end else if (b0[7] == 1'b0) begin
            d.cp  = {13'd0, b0};
            d.len = 3'd1;
        end else if ((b0 & 8'he0) == 8'hc0 && c1) begin
            d.cp  = {10'd0, b0[4:0], b1[5:0]};
            d.len = 3'd2;
        end else if ((b0 & 8'hf0) == 8'he0 && c1 && c2) begin
            d.cp  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            d.len = 3'd3;
        end else if ((b0 & 8'hf8) == 8'hf0 && c1 && c2 && c3) begin
            d.cp  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            d.len = 3'd4;
        end else begin
            d.cp  = CP_REPLACEMENT;
            d.len = 3'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: sv/wtm_ram.sv
// ----------------------------------------------------------------------------
// wtm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/wrapped_text_measure.sv
// ----------------------------------------------------------------------------
// wrapped_text_measure: greedy word-wrap text measurement
// Loads glyph and kerning tables, buffers UTF-8 text and measures its
// wrapped layout with one shared binary-search compare unit.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake               Payload
// command    in         start & !busy           operation .. last
// result     out        done (one-cycle strobe) max_width .. text_overflow
// config     in         cfg_we                  cfg_index, cfg_data
//
// Table loads and non-final text bytes are taken while idle; busy stays low.
// A text byte marked last starts the measurement: each character's four
// bytes are read and captured in turn and decoded; a printing character is
// then binary-searched in the glyph and kerning tables, a read and a compare
// per probe, and steps the line; the memory read port and the shared
// compare unit set this order. Reset clears control state only; the tables
// and text buffer hold nothing valid until written. The result receiver
// cannot stall: done is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_text_measure
    import wtm_pkg::*;
#(
    parameter int GLYPH_DEPTH = GLYPH_DEPTH_DEF,
    parameter int KERN_DEPTH  = KERN_DEPTH_DEF,
    parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              operation,
    input  wire logic [IDX_W-1:0]        entry_index,
    input  wire logic [CP_W-1:0]         code_point,
    input  wire logic [CP_W-1:0]         second_code_point,
    input  wire logic signed [ADV_W-1:0] advance,
    input  wire logic [7:0]              text_byte,
    input  wire logic                    last,
    input  wire logic                    cfg_we,
    input  wire logic [CFGI_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    output logic                         done,
    output logic signed [15:0]           max_width,
    output logic signed [15:0]           total_height,
    output logic [10:0]                  line_count,
    output logic                         text_overflow
);

    localparam int GAW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
    localparam int KAW = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
    localparam int TAW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int GSW = $clog2(GLYPH_DEPTH + 1);
    localparam int KSW = $clog2(KERN_DEPTH + 1);
    localparam int SW  = (GSW > KSW) ? GSW : KSW;
    localparam int LW  = $clog2(TEXT_DEPTH + 1);
    localparam int PW  = $clog2(TEXT_DEPTH + 4);
    localparam int GDW = CP_W + ADV_W;
    localparam int KDW = 2 * CP_W + ADV_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CAP  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_SRCH = 3'd4;
    localparam logic [2:0] S_SCMP = 3'd5;
    localparam logic [2:0] S_STEP = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // What the shared search unit is looking for.
    localparam logic [1:0] SK_GLYPH_CP = 2'd0;
    localparam logic [1:0] SK_GLYPH_Q  = 2'd1;
    localparam logic [1:0] SK_KERN     = 2'd2;

    // Configuration registers.
    logic [14:0] wrap_width_reg;
    logic [9:0]  line_height_reg;
    logic [8:0]  glyph_count_reg;
    logic [9:0]  kern_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_width_reg  <= '0;
            line_height_reg <= '0;
            glyph_count_reg <= '0;
            kern_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WRAP_WIDTH:  wrap_width_reg  <= cfg_data;
                REG_LINE_HEIGHT: line_height_reg <= cfg_data[9:0];
                REG_GLYPH_COUNT: glyph_count_reg <= cfg_data[8:0];
                REG_KERN_COUNT:  kern_count_reg  <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    // Control and datapath registers.
    logic [2:0]              state_reg, state_next;
    logic [LW-1:0]           len_reg, len_next;
    logic                    ovf_reg, ovf_next;
    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           start_reg, start_next;
    logic [1:0]              cnt_reg, cnt_next;
    logic                    bval_reg, bval_next;
    logic [7:0]              b_reg [4];
    logic [7:0]              b_next [4];
    logic [CP_W-1:0]         cp_reg, cp_next;
    logic [PW-1:0]           j_reg, j_next;
    logic [CP_W-1:0]         prev_reg, prev_next;
    logic signed [15:0]      w_reg, w_next;
    logic signed [15:0]      g_reg, g_next;
    logic signed [15:0]      adv_reg, adv_next;
    logic                    brk_v_reg, brk_v_next;
    logic [PW-1:0]           brk_pos_reg, brk_pos_next;
    logic signed [15:0]      brk_w_reg, brk_w_next;
    logic                    skip_reg, skip_next;
    logic signed [15:0]      maxw_reg, maxw_next;
    logic [15:0]             lines_reg, lines_next;
    logic [1:0]              sk_reg, sk_next;
    logic [2*CP_W-1:0]       key_reg, key_next;
    logic [SW-1:0]           lo_reg, lo_next;
    logic [SW-1:0]           hi_reg, hi_next;
    logic [SW-1:0]           mid_reg, mid_next;
    logic                    done_reg;
    logic signed [15:0]      maxw_out_reg;
    logic signed [15:0]      height_reg;
    logic [10:0]             lcnt_reg;
    logic                    ovf_out_reg;

    // Memories.
    logic [GDW-1:0] glyph_rdata;
    logic [KDW-1:0] kern_rdata;
    logic [7:0]     text_rdata;
    logic           accept;
    logic           glyph_we, kern_we, text_we;
    logic [SW:0]    mid_sum;
    logic [SW-1:0]  mid;
    logic [PW-1:0]  rd_pos;

    assign accept   = start && !busy;
    assign glyph_we = accept && operation == OP_GLYPH && 32'(entry_index) < GLYPH_DEPTH;
    assign kern_we  = accept && operation == OP_KERN && 32'(entry_index) < KERN_DEPTH;
    assign text_we  = accept && operation == OP_TEXT && 32'(len_reg) < TEXT_DEPTH;
    assign mid_sum  = ({1'b0, lo_reg} + {1'b0, hi_reg} - (SW+1)'(1)) >> 1;
    assign mid      = mid_sum[SW-1:0];
    assign rd_pos   = pos_reg + PW'(cnt_reg);

    wtm_ram #(.WIDTH(GDW), .DEPTH(GLYPH_DEPTH), .AW(GAW)) u_glyph_ram (
        .clk   (clk),
        .we    (glyph_we),
        .waddr (entry_index[GAW-1:0]),
        .wdata ({code_point, advance}),
        .raddr (mid[GAW-1:0]),
        .rdata (glyph_rdata)
    );

    wtm_ram #(.WIDTH(KDW), .DEPTH(KERN_DEPTH), .AW(KAW)) u_kern_ram (
        .clk   (clk),
        .we    (kern_we),
        .waddr (entry_index[KAW-1:0]),
        .wdata ({code_point, second_code_point, advance}),
        .raddr (mid[KAW-1:0]),
        .rdata (kern_rdata)
    );

    wtm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH), .AW(TAW)) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (len_reg[TAW-1:0]),
        .wdata (text_byte),
        .raddr (rd_pos[TAW-1:0]),
        .rdata (text_rdata)
    );

    // Shared compare unit: the key against the entry just read.
    logic [2*CP_W-1:0] entry_key;
    logic              key_eq, key_lt;
    logic [SW-1:0]     glyph_n, kern_n;
    decode_t           dec;
    logic signed [17:0] sum18;
    logic              over;
    logic signed [15:0] w_add;
    logic signed [15:0] line_w;

    assign entry_key = (sk_reg == SK_KERN) ? kern_rdata[KDW-1:ADV_W]
                                           : {glyph_rdata[GDW-1:ADV_W], {CP_W{1'b0}}};
    assign key_eq    = entry_key == key_reg;
    assign key_lt    = entry_key < key_reg;
    assign glyph_n   = (32'(glyph_count_reg) < GLYPH_DEPTH) ? SW'(glyph_count_reg)
                                                            : SW'(GLYPH_DEPTH);
    assign kern_n    = (32'(kern_count_reg) < KERN_DEPTH) ? SW'(kern_count_reg)
                                                          : SW'(KERN_DEPTH);
    assign dec       = utf8_decode(b_reg[0], b_reg[1], b_reg[2], b_reg[3]);

    // Wrap test uses the unwrapped sum; the running width wraps at 16 bits.
    assign sum18  = 18'(w_reg) + 18'(adv_reg);
    assign over   = wrap_width_reg != '0 && sum18 > $signed({3'b000, wrap_width_reg})
                    && pos_reg != start_reg;
    assign w_add  = w_reg + adv_reg;
    assign line_w = brk_v_reg ? brk_w_reg : w_reg;

    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        pos_next     = pos_reg;
        start_next   = start_reg;
        cnt_next     = cnt_reg;
        bval_next    = bval_reg;
        b_next       = b_reg;
        cp_next      = cp_reg;
        j_next       = j_reg;
        prev_next    = prev_reg;
        w_next       = w_reg;
        g_next       = g_reg;
        adv_next     = adv_reg;
        brk_v_next   = brk_v_reg;
        brk_pos_next = brk_pos_reg;
        brk_w_next   = brk_w_reg;
        skip_next    = skip_reg;
        maxw_next    = maxw_reg;
        lines_next   = lines_reg;
        sk_next      = sk_reg;
        key_next     = key_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_TEXT)
                begin
                    if (32'(len_reg) < TEXT_DEPTH)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        pos_next   = '0;
                        start_next = '0;
                        cnt_next   = '0;
                        w_next     = '0;
                        brk_v_next = 1'b0;
                        prev_next  = '0;
                        maxw_next  = '0;
                        lines_next = 16'd1;
                        skip_next  = 1'b0;
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                // Bytes at or beyond the text length read as zero.
                bval_next  = rd_pos < PW'(len_reg);
                state_next = S_CAP;
            end

            S_CAP:
            begin
                b_next[cnt_reg] = bval_reg ? text_rdata : 8'h00;
                cnt_next        = cnt_reg + 2'd1;
                state_next      = (cnt_reg == 2'd3) ? S_DEC : S_RD;
            end

            S_DEC:
            begin
                cp_next = dec.cp;
                j_next  = pos_reg + PW'(dec.len);
                if (skip_reg)
                begin
                    // Leading spaces after a wrap are dropped.
                    if (dec.cp == CP_SPACE)
                    begin
                        pos_next = pos_reg + PW'(dec.len);
                    end
                    else
                    begin
                        skip_next  = 1'b0;
                        start_next = pos_reg;
                        w_next     = '0;
                        brk_v_next = 1'b0;
                        prev_next  = '0;
                    end
                    state_next = S_RD;
                end
                else if (dec.cp == '0)
                begin
                    if (w_reg > maxw_reg)
                    begin
                        maxw_next = w_reg;
                    end
                    state_next = S_FIN;
                end
                else if (dec.cp == CP_NEWLINE)
                begin
                    if (w_reg > maxw_reg)
                    begin
                        maxw_next = w_reg;
                    end
                    lines_next = lines_reg + 16'd1;
                    pos_next   = pos_reg + PW'(dec.len);
                    start_next = pos_reg + PW'(dec.len);
                    w_next     = '0;
                    brk_v_next = 1'b0;
                    prev_next  = '0;
                    state_next = S_RD;
                end
                else
                begin
                    sk_next    = SK_GLYPH_CP;
                    key_next   = {dec.cp, {CP_W{1'b0}}};
                    lo_next    = '0;
                    hi_next    = glyph_n;
                    state_next = S_SRCH;
                end
            end

            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_SCMP;
                end
                else
                begin
                    // Entry not found.
                    case (sk_reg)
                        SK_GLYPH_CP:
                        begin
                            if (cp_reg == CP_QUESTION)
                            begin
                                adv_next   = '0;
                                state_next = S_STEP;
                            end
                            else
                            begin
                                sk_next  = SK_GLYPH_Q;
                                key_next = {CP_QUESTION, {CP_W{1'b0}}};
                                lo_next  = '0;
                                hi_next  = glyph_n;
                            end
                        end
                        SK_GLYPH_Q:
                        begin
                            adv_next   = '0;
                            state_next = S_STEP;
                        end
                        default:
                        begin
                            adv_next   = g_reg;
                            state_next = S_STEP;
                        end
                    endcase
                end
            end

            S_SCMP:
            begin
                state_next = S_SRCH;
                if (key_eq)
                begin
                    if (sk_reg == SK_KERN)
                    begin
                        adv_next   = g_reg + $signed(kern_rdata[ADV_W-1:0]);
                        state_next = S_STEP;
                    end
                    else if (prev_reg != '0)
                    begin
                        g_next   = $signed(glyph_rdata[ADV_W-1:0]);
                        sk_next  = SK_KERN;
                        key_next = {prev_reg, cp_reg};
                        lo_next  = '0;
                        hi_next  = kern_n;
                    end
                    else
                    begin
                        adv_next   = $signed(glyph_rdata[ADV_W-1:0]);
                        state_next = S_STEP;
                    end
                end
                else if (key_lt)
                begin
                    lo_next = mid_reg + SW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end

            S_STEP:
            begin
                if (over)
                begin
                    // Break at the last space or hyphen, else before this glyph.
                    if (line_w > maxw_reg)
                    begin
                        maxw_next = line_w;
                    end
                    lines_next = lines_reg + 16'd1;
                    if (brk_v_reg)
                    begin
                        pos_next = brk_pos_reg;
                    end
                    skip_next = 1'b1;
                end
                else
                begin
                    w_next = w_add;
                    if (cp_reg == CP_SPACE)
                    begin
                        brk_v_next   = 1'b1;
                        brk_pos_next = j_reg;
                        brk_w_next   = w_reg;
                    end
                    else if (cp_reg == CP_HYPHEN)
                    begin
                        brk_v_next   = 1'b1;
                        brk_pos_next = j_reg;
                        brk_w_next   = w_add;
                    end
                    prev_next = cp_reg;
                    pos_next  = j_reg;
                end
                state_next = S_RD;
            end

            S_FIN:
            begin
                len_next   = '0;
                ovf_next   = 1'b0;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
            skip_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            done_reg  <= state_reg == S_FIN;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        start_reg   <= start_next;
        bval_reg    <= bval_next;
        b_reg       <= b_next;
        cp_reg      <= cp_next;
        j_reg       <= j_next;
        prev_reg    <= prev_next;
        w_reg       <= w_next;
        g_reg       <= g_next;
        adv_reg     <= adv_next;
        brk_v_reg   <= brk_v_next;
        brk_pos_reg <= brk_pos_next;
        brk_w_reg   <= brk_w_next;
        maxw_reg    <= maxw_next;
        lines_reg   <= lines_next;
        sk_reg      <= sk_next;
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        if (state_reg == S_FIN)
        begin
            // Height is the line count times the line height, low 16 bits.
            maxw_out_reg <= maxw_reg;
            height_reg   <= 16'(lines_reg * 16'(line_height_reg));
            lcnt_reg     <= lines_reg[10:0];
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign busy          = state_reg != S_IDLE;
    assign done          = done_reg;
    assign max_width     = maxw_out_reg;
    assign total_height  = height_reg;
    assign line_count    = lcnt_reg;
    assign text_overflow = ovf_out_reg;

endmodule

`default_nettype wire

// File: sim/wrapped_text_measure_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_text_measure_tb: self-checking bench for wrapped text measurement
// Loads sorted glyph and kerning tables, streams UTF-8 texts with random
// wrap widths, line heights and table sizes, and checks each measurement
// against a layout predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module wrapped_text_measure_tb;
    import wtm_pkg::*;

    localparam logic [1:0] OP_NOP    = 2'd3;
    localparam int         WDOG_MAX  = 400000;
    localparam int         GLYPHS    = GLYPH_DEPTH_DEF;
    localparam int         KERNS     = KERN_DEPTH_DEF;
    localparam int         TEXT_MAX  = TEXT_DEPTH_DEF;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [10:0] lines;
        logic        ovf;
    } measure_t;

    // The scoreboard mirrors the tables, the text buffer and the registers,
    // lays out the text on every final byte, and queues the measurement.
    class layout_board;
        logic [CP_W-1:0] glyph_cp[GLYPHS];
        shortint         glyph_adv[GLYPHS];
        logic [CP_W-1:0] kern_a[KERNS];
        logic [CP_W-1:0] kern_b[KERNS];
        shortint         kern_adj[KERNS];
        logic [7:0]      text_buf[TEXT_MAX];
        int              text_len;
        bit              dropped;
        int              wrap_w, line_h, glyph_n, kern_n;
        measure_t        pending[$];
        int              errors;
        int              measured;

        function new();
            text_len = 0; dropped = 0; errors = 0; measured = 0;
            wrap_w = 0; line_h = 0; glyph_n = 0; kern_n = 0;
        endfunction

        function void set_reg(logic [CFGI_W-1:0] idx, int val);
            case (idx)
                REG_WRAP_WIDTH:  wrap_w  = val & 16'h7fff;
                REG_LINE_HEIGHT: line_h  = val & 16'h03ff;
                REG_GLYPH_COUNT: glyph_n = val & 16'h01ff;
                default:         kern_n  = val & 16'h03ff;
            endcase
        endfunction

        function int wrap16(int v);
            return int'(shortint'(v));
        endfunction

        function logic [7:0] byte_at(int pos);
            if (pos < 0 || pos >= text_len) return 8'h00;
            return text_buf[pos];
        endfunction

        // Decodes one character at pos; nx is where the next one starts.
        function logic [CP_W-1:0] decode(int pos, output int nx);
            logic [7:0] b0, b1, b2, b3;
            bit c1, c2, c3;
            b0 = byte_at(pos); b1 = byte_at(pos + 1);
            b2 = byte_at(pos + 2); b3 = byte_at(pos + 3);
            c1 = b1[7:6] == 2'b10; c2 = b2[7:6] == 2'b10; c3 = b3[7:6] == 2'b10;
            nx = pos;
            if (b0 == 8'h00) return '0;
            if (!b0[7]) begin nx = pos + 1; return CP_W'(b0); end
            if (b0[7:5] == 3'b110 && c1) begin
                nx = pos + 2;
                return CP_W'({b0[4:0], b1[5:0]});
            end
            if (b0[7:4] == 4'b1110 && c1 && c2) begin
                nx = pos + 3;
                return CP_W'({b0[3:0], b1[5:0], b2[5:0]});
            end
            if (b0[7:3] == 5'b11110 && c1 && c2 && c3) begin
                nx = pos + 4;
                return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
            nx = pos + 1;
            return CP_REPLACEMENT;
        endfunction

        function bit glyph_lookup(logic [CP_W-1:0] cp, output int adv);
            int lo, hi, mid;
            lo = 0; hi = (glyph_n < GLYPHS ? glyph_n : GLYPHS) - 1;
            adv = 0;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (glyph_cp[mid] == cp) begin adv = glyph_adv[mid]; return 1; end
                if (glyph_cp[mid] < cp) lo = mid + 1;
                else hi = mid - 1;
            end
            return 0;
        endfunction

        function int kern_lookup(logic [CP_W-1:0] a, logic [CP_W-1:0] b);
            int lo, hi, mid;
            lo = 0; hi = (kern_n < KERNS ? kern_n : KERNS) - 1;
            if (a == 0) return 0;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (kern_a[mid] == a && kern_b[mid] == b) return kern_adj[mid];
                if (kern_a[mid] < a || (kern_a[mid] == a && kern_b[mid] < b)) lo = mid + 1;
                else hi = mid - 1;
            end
            return 0;
        endfunction

        // A missing glyph falls back to the question mark; if that is
        // missing too the character is zero wide and gets no kerning.
        function int advance_for(logic [CP_W-1:0] prev, logic [CP_W-1:0] cp);
            int g;
            if (!glyph_lookup(cp, g)) begin
                if (cp == CP_QUESTION || !glyph_lookup(CP_QUESTION, g)) return 0;
            end
            return wrap16(g + kern_lookup(prev, cp));
        endfunction

        // Lays out one line from s; returns the next line start or -1.
        function int fit_line(int s, output int width);
            int i, brk, w, brk_w, j, adv, k, k2;
            logic [CP_W-1:0] prev, cp;
            i = s; brk = -1; w = 0; brk_w = 0; prev = '0;
            width = 0;
            while (1) begin
                cp = decode(i, j);
                if (cp == 0) begin width = w; return -1; end
                if (cp == CP_NEWLINE) begin width = w; return j; end
                adv = advance_for(prev, cp);
                if (wrap_w > 0 && w + adv > wrap_w && i > s) begin
                    if (brk >= 0) begin width = brk_w; k = brk; end
                    else begin width = w; k = i; end
                    while (decode(k, k2) == CP_SPACE) k = k2;
                    return k;
                end
                w = wrap16(w + adv);
                if (cp == CP_SPACE) begin brk = j; brk_w = wrap16(w - adv); end
                if (cp == CP_HYPHEN) begin brk = j; brk_w = w; end
                prev = cp;
                i = j;
            end
            return -1;
        endfunction

        function void note_input(logic [1:0] op, logic [IDX_W-1:0] idx,
                                 logic [CP_W-1:0] cp1, logic [CP_W-1:0] cp2,
                                 logic [15:0] adv, logic [7:0] tb, logic lst);
            int pos, w, widest, lines;
            measure_t m;
            if (op == OP_GLYPH) begin
                if (idx < GLYPHS) begin glyph_cp[idx] = cp1; glyph_adv[idx] = adv; end
                return;
            end
            if (op == OP_KERN) begin
                kern_a[idx] = cp1; kern_b[idx] = cp2; kern_adj[idx] = adv;
                return;
            end
            if (op != OP_TEXT) return;
            if (text_len < TEXT_MAX) begin text_buf[text_len] = tb; text_len++; end
            else dropped = 1;
            if (!lst) return;
            pos = 0; widest = 0; lines = 1;
            while (1) begin
                pos = fit_line(pos, w);
                if (w > widest) widest = w;
                if (pos < 0) break;
                lines++;
            end
            m.width  = 16'(widest);
            m.height = 16'(lines * line_h);
            m.lines  = 11'(lines);
            m.ovf    = dropped;
            pending.push_back(m);
            text_len = 0;
            dropped = 0;
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_result(logic [15:0] w, logic [15:0] h, logic [10:0] n, logic ov);
            measure_t m;
            if (pending.size() == 0) begin
                report("unexpected result, width", w, 16'h0);
                return;
            end
            m = pending.pop_front();
            measured++;
            if (w !== m.width)  report("max_width", w, m.width);
            if (h !== m.height) report("total_height", h, m.height);
            if (n !== m.lines)  report("line_count", 16'(n), 16'(m.lines));
            if (ov !== m.ovf)   report("text_overflow", 16'(ov), 16'(m.ovf));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              operation;
    logic [IDX_W-1:0]        entry_index;
    logic [CP_W-1:0]         code_point;
    logic [CP_W-1:0]         second_code_point;
    logic signed [ADV_W-1:0] advance;
    logic [7:0]              text_byte;
    logic                    last;
    logic                    cfg_we;
    logic [CFGI_W-1:0]       cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    done;
    logic signed [15:0]      max_width;
    logic signed [15:0]      total_height;
    logic [10:0]             line_count;
    logic                    text_overflow;

    layout_board board;
    int          gap_pct;
    int          sent;
    int          texts;
    int          idle_cycles;

    wrapped_text_measure uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .entry_index(entry_index), .code_point(code_point),
        .second_code_point(second_code_point), .advance(advance),
        .text_byte(text_byte), .last(last), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .max_width(max_width),
        .total_height(total_height), .line_count(line_count),
        .text_overflow(text_overflow)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off, so every strobe is checked as it comes.
    always @(posedge clk) begin
        if (rst_n && done)
            board.check_result(max_width, total_height, line_count, text_overflow);
    end

    // The watchdog counts cycles in which no transfer happens on either side.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drives one command and waits for its transfer. Inputs only move at the
    // falling edge; busy is sampled at the rising edge before it updates.
    task automatic send(logic [1:0] op, logic [IDX_W-1:0] idx, logic [CP_W-1:0] cp1,
                        logic [CP_W-1:0] cp2, logic [15:0] adv, logic [7:0] tb,
                        logic lst);
        bit taken;
        while ($urandom_range(0, 99) < gap_pct) begin
            start = 1'b0;
            @(negedge clk);
        end
        operation = op; entry_index = idx; code_point = cp1;
        second_code_point = cp2; advance = adv; text_byte = tb; last = lst;
        start = 1'b1;
        taken = 0;
        while (!taken) begin
            @(posedge clk);
            taken = !busy;
        end
        board.note_input(op, idx, cp1, cp2, adv, tb, lst);
        sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic send_text(logic [7:0] bytes[$]);
        foreach (bytes[i])
            send(OP_TEXT, IDX_W'($urandom), CP_W'($urandom), CP_W'($urandom),
                 16'($urandom), bytes[i], i == bytes.size() - 1);
        texts++;
    endtask

    // Holds off until every expected measurement has come back, then lets
    // the block settle before the registers change.
    task automatic drain();
        start = 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, int val);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = CFG_W'(val);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_layout(int ww, int lh, int gc, int kc);
        drain();
        write_reg(REG_WRAP_WIDTH, ww);
        write_reg(REG_LINE_HEIGHT, lh);
        write_reg(REG_GLYPH_COUNT, gc);
        write_reg(REG_KERN_COUNT, kc);
    endtask

    // Sorted glyph codes: printable ASCII, Latin-1, a run of CJK ideographs,
    // the replacement character and a few emoji at the top.
    function automatic logic [CP_W-1:0] glyph_code(int i);
        if (i < 95)  return CP_W'(32'h20 + i);
        if (i < 191) return CP_W'(32'ha0 + i - 95);
        if (i < 250) return CP_W'(32'h4e00 + (i - 191) * 3);
        if (i == 250) return CP_REPLACEMENT;
        return CP_W'(32'h1f600 + i - 251);
    endfunction

    // Appends one random character: mostly letters, with spaces, hyphens,
    // newlines, question marks, other punctuation and multi-byte forms mixed in.
    task automatic add_char(ref logic [7:0] q[$]);
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 50) q.push_back(8'($urandom_range(8'h61, 8'h7a)));
        else if (r < 62) q.push_back(8'($urandom_range(8'h41, 8'h5a)));
        else if (r < 74) q.push_back(8'h20);
        else if (r < 80) q.push_back(8'h2d);
        else if (r < 83) q.push_back(8'h0a);
        else if (r < 87) begin
            g = $urandom_range(8'ha0, 8'hff);
            q.push_back(8'hc0 | 8'(g >> 6)); q.push_back(8'h80 | 8'(g & 63));
        end else if (r < 91) begin
            g = 32'h4e00 + 3 * $urandom_range(0, 60);
            q.push_back(8'he0 | 8'(g >> 12));
            q.push_back(8'h80 | 8'((g >> 6) & 63)); q.push_back(8'h80 | 8'(g & 63));
        end else if (r < 94) begin
            g = 32'h1f600 + $urandom_range(0, 6);
            q.push_back(8'hf0 | 8'(g >> 18)); q.push_back(8'h80 | 8'((g >> 12) & 63));
            q.push_back(8'h80 | 8'((g >> 6) & 63)); q.push_back(8'h80 | 8'(g & 63));
        end else if (r < 96) q.push_back(8'h3f);
        else q.push_back(8'($urandom_range(8'h7b, 8'h7e)));
    endtask

    initial begin
        logic [7:0] q[$];
        int n, adv, phase, quota;
        board = new();
        rst_n = 1'b0; start = 1'b0; operation = OP_NOP; entry_index = '0;
        code_point = '0; second_code_point = '0; advance = '0; text_byte = '0;
        last = 1'b0; cfg_we = 1'b0; cfg_index = REG_WRAP_WIDTH; cfg_data = '0;
        gap_pct = 28; sent = 0; texts = 0; idle_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill both tables completely so any count reads written entries only.
        // The tilde and closing brace glyphs carry the extreme advances.
        for (int i = 0; i < GLYPHS; i++) begin
            adv = $urandom_range(1, 20);
            if (glyph_code(i) == 21'h7e) adv = 32767;
            if (glyph_code(i) == 21'h7d) adv = -32768;
            send(OP_GLYPH, IDX_W'(i), glyph_code(i), CP_W'($urandom), 16'(adv),
                 8'($urandom), 1'b0);
        end
        for (int k = 0; k < KERNS; k++)
            send(OP_KERN, IDX_W'(k), CP_W'(32'h20 + k / 8), CP_W'(32'h41 + (k % 8) * 4),
                 16'($urandom_range(0, 6) - 3), 8'($urandom), 1'b0);

        // Directed part.
        set_layout(40, 12, GLYPHS, KERNS);
        // A glyph load past the table end is ignored, and so is its last bit.
        send(OP_GLYPH, IDX_W'(300), {CP_W{1'b1}}, {CP_W{1'b1}}, 16'hffff, 8'hff, 1'b1);
        send(OP_NOP, '1, '1, '1, 16'h8000, 8'h80, 1'b1);
        send_text('{8'h00});                                 // empty text
        send_text('{8'h61, 8'h62, 8'h0a, 8'h63});            // newline
        send_text('{8'hff, 8'h61});                          // invalid lead byte
        send_text('{8'hc0, 8'h80, 8'h61});                   // overlong zero ends text
        send_text('{8'h61, 8'he4});                          // sequence cut at the end
        send_text('{8'hf0, 8'h9f, 8'h98, 8'h80, 8'hc3, 8'ha9});
        send_text('{8'h7e, 8'h7e, 8'h7d});                   // extreme advances
        send_text('{8'h61, 8'h61, 8'h2d, 8'h62, 8'h62, 8'h20, 8'h20, 8'h63, 8'h63});

        // Random part: three idling modes, four register settings each.
        for (phase = 0; phase < 12; phase++) begin
            gap_pct = phase < 4 ? 28 : (phase < 8 ? 57 : 0);
            case (phase % 4)
                0: set_layout(0, 1023, GLYPHS, KERNS);
                1: set_layout(32767, 0, 0, 0);
                2: set_layout(1, 1, 31, 1);            // question mark glyph missing
                default: set_layout($urandom_range(5, 200), $urandom_range(0, 1023),
                                    $urandom_range(0, GLYPHS), $urandom_range(0, KERNS));
            endcase
            quota = sent + 110;
            if (phase == 5) begin
                // Overrun the buffer; the early zero keeps the layout short.
                q.delete();
                q.push_back(8'h61); q.push_back(8'h00);
                for (int i = 0; i < TEXT_MAX + 4; i++) q.push_back(8'($urandom));
                send_text(q);
            end
            while (sent < quota) begin
                q.delete();
                n = $urandom_range(1, 30);
                if ($urandom_range(0, 9) < 8) begin
                    for (int i = 0; i < n; i++) add_char(q);
                end else begin
                    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
                end
                if ($urandom_range(0, 9) == 0)
                    send(($urandom_range(0, 1) != 0) ? OP_NOP : OP_GLYPH,
                         IDX_W'($urandom_range(256, 511)), CP_W'($urandom),
                         CP_W'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
                send_text(q);
            end
        end

        drain();
        repeat (50) @(negedge clk);
        $display("Covered %0d transfers and %0d texts, %0d measurements checked,",
                 sent, texts, board.measured);
        $display("over twelve register settings and three sender idling modes.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: wrapped_text_measure.f
sv/wtm_pkg.sv
sv/wtm_ram.sv
sv/wrapped_text_measure.sv
sim/wrapped_text_measure_tb.sv
